/* sv/btr_pkg.sv */
// Shared types, codes and numeral tables for the binary to Roman numeral block.
// Used by btr_ctrl, btr_dp and binary_to_roman_numeral; no dependencies.
package btr_pkg;

  localparam int VALUE_W  = 12;
  localparam int SYMBOL_W = 7;
  localparam int BCD_W    = 16;

  localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

  // ASCII codes of the numerals
  localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;
  localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
  localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
  localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
  localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
  localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;

  // decimal places
  localparam logic [1:0] PL_UNITS     = 2'd0;
  localparam logic [1:0] PL_TENS      = 2'd1;
  localparam logic [1:0] PL_HUNDREDS  = 2'd2;
  localparam logic [1:0] PL_THOUSANDS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SEEK,
    S_EMIT,
    S_ERR
  } state_t;

  typedef enum logic [1:0] {
    K_ONE,
    K_FIVE,
    K_TEN
  } kind_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic next_char;
    logic next_place;
  } cmd_t;

  typedef struct packed {
    logic bad;          // input value out of range
    logic conv_done;    // current step is the final conversion step
    logic digit_empty;  // current place has no characters
    logic char_last;    // current char ends its digit
    logic all_last;     // current char ends the numeral
  } status_t;

  // number of characters written for one decimal digit
  function automatic logic [2:0] char_count(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // which symbol of the place the k-th character of digit d uses
  function automatic kind_t char_kind(input logic [3:0] d, input logic [1:0] k);
    kind_t r;
    r = K_ONE;
    if (d == 4'd4) begin
      r = (k == 2'd0) ? K_ONE : K_FIVE;
    end else if (d == 4'd9) begin
      r = (k == 2'd0) ? K_ONE : K_TEN;
    end else if (d >= 4'd5) begin
      r = (k == 2'd0) ? K_FIVE : K_ONE;
    end
    return r;
  endfunction

  function automatic logic [SYMBOL_W-1:0] place_sym(input logic [1:0] place,
                                                    input kind_t kind);
    logic [SYMBOL_W-1:0] c;
    c = CH_NONE;
    unique case (place)
      PL_UNITS: begin
        unique case (kind)
          K_ONE:   c = CH_I;
          K_FIVE:  c = CH_V;
          K_TEN:   c = CH_X;
          default: c = CH_NONE;
        endcase
      end
      PL_TENS: begin
        unique case (kind)
          K_ONE:   c = CH_X;
          K_FIVE:  c = CH_L;
          K_TEN:   c = CH_C;
          default: c = CH_NONE;
        endcase
      end
      PL_HUNDREDS: begin
        unique case (kind)
          K_ONE:   c = CH_C;
          K_FIVE:  c = CH_D;
          K_TEN:   c = CH_M;
          default: c = CH_NONE;
        endcase
      end
      default: begin
        // thousands only ever uses its unit symbol
        c = (kind == K_ONE) ? CH_M : CH_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

/* sv/btr_ctrl.sv */
// Controller FSM for the Roman numeral block: sequences load, BCD conversion,
// digit seek and character emission. Depends on btr_pkg.
module btr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             err_beat,
  input  btr_pkg::status_t sts,
  output btr_pkg::cmd_t    cmd
);
  import btr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    err_beat   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.bad ? S_ERR : S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_next = S_SEEK;
        end
      end
      S_SEEK: begin
        // skip places whose digit is zero
        if (sts.digit_empty) begin
          cmd.next_place = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.all_last) begin
            state_next = S_IDLE;
          end else if (sts.char_last) begin
            cmd.next_place = 1'b1;
            state_next     = S_SEEK;
          end else begin
            cmd.next_char = 1'b1;
          end
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        err_beat  = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/btr_dp.sv */
// Datapath for the Roman numeral block: double-dabble BCD conversion, three
// bits per cycle, plus place/character pointers and symbol lookup. Depends on btr_pkg.
module btr_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [btr_pkg::VALUE_W-1:0]      value,
  input  btr_pkg::cmd_t                    cmd,
  input  logic                             err_beat,
  output btr_pkg::status_t                 sts,
  output logic [btr_pkg::SYMBOL_W-1:0]     symbol,
  output logic                             last,
  output logic                             range_error
);
  import btr_pkg::*;

  localparam int SH_W = BCD_W + VALUE_W;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [1:0]         cnt;
  logic [1:0]         place;
  logic [1:0]         k;

  logic [SH_W-1:0]    sh;
  logic [3:0]         digit;
  logic [2:0]         n;
  logic               lower_zero;

  // three shift-and-adjust steps per cycle; the conversion steps together cover 12 bits
  always_comb begin
    sh = {bcd, bin};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (sh[VALUE_W + 4*j +: 4] >= 4'd5) begin
          sh[VALUE_W + 4*j +: 4] = sh[VALUE_W + 4*j +: 4] + 4'd3;
        end
      end
      sh = {sh[SH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin   <= '0;
      bcd   <= '0;
      cnt   <= '0;
      place <= PL_THOUSANDS;
      k     <= '0;
    end else if (cmd.load) begin
      bin   <= value;
      bcd   <= '0;
      cnt   <= '0;
      place <= PL_THOUSANDS;
      k     <= '0;
    end else begin
      if (cmd.conv_step) begin
        bcd <= sh[SH_W-1:VALUE_W];
        bin <= sh[VALUE_W-1:0];
        cnt <= cnt + 2'd1;
      end
      if (cmd.next_place) begin
        place <= place - 2'd1;
        k     <= '0;
      end else if (cmd.next_char) begin
        k <= k + 2'd1;
      end
    end
  end

  always_comb begin
    unique case (place)
      PL_UNITS:    begin digit = bcd[3:0];   lower_zero = 1'b1;               end
      PL_TENS:     begin digit = bcd[7:4];   lower_zero = (bcd[3:0] == '0);   end
      PL_HUNDREDS: begin digit = bcd[11:8];  lower_zero = (bcd[7:0] == '0);   end
      default:     begin digit = bcd[15:12]; lower_zero = (bcd[11:0] == '0);  end
    endcase
  end

  assign n = char_count(digit);

  always_comb begin
    sts.bad         = (value == '0) || (value > MAX_VALID);
    sts.conv_done   = (cnt == 2'd3);
    sts.digit_empty = (n == 3'd0);
    sts.char_last   = ({1'b0, k} == (n - 3'd1));
    sts.all_last    = sts.char_last && lower_zero;
  end

  assign symbol      = err_beat ? CH_NONE : place_sym(place, char_kind(digit, k));
  assign last        = err_beat | (sts.char_last & lower_zero);
  assign range_error = err_beat;

endmodule

/* sv/binary_to_roman_numeral.sv */
// Top level: 12-bit binary integer in, Roman numeral out one ASCII char per beat.
// Instantiates btr_ctrl and btr_dp; depends on btr_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   input   | in_valid / in_stall  | value[11:0]
//   output  | out_valid / out_stall| symbol[6:0], last, range_error
//
// One item at a time: accept in idle, BCD conversion (double dabble, three
// bits per cycle), a seek step for each nonzero decimal digit and every skipped
// zero place, then one beat per character (1 to 15).
// Out-of-range values skip conversion and give a single error beat.
// A stall on the output holds the current beat; in_stall is high while busy.
// Reset (rst, synchronous) returns the controller to idle.
module binary_to_roman_numeral (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [btr_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [btr_pkg::SYMBOL_W-1:0] symbol,
  output logic                         last,
  output logic                         range_error
);
  import btr_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    err_beat;

  btr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .err_beat  (err_beat),
    .sts       (sts),
    .cmd       (cmd)
  );

  btr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .err_beat    (err_beat),
    .sts         (sts),
    .symbol      (symbol),
    .last        (last),
    .range_error (range_error)
  );

endmodule

/* test/roman_check.sv */
// Checker for binary_to_roman_numeral: predicts the numeral beats of each accepted
// value and compares them with the output channel. Depends on btr_pkg.
`timescale 1ns / 1ps

module roman_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [btr_pkg::VALUE_W-1:0]  value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [btr_pkg::SYMBOL_W-1:0] symbol,
  input  logic                         last,
  input  logic                         range_error,
  output int                           fail_count,
  output int                           pending
);
  import btr_pkg::*;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                range_error;
  } numeral_beat_t;

  numeral_beat_t numeral_q[$];

  function automatic void push_char(input logic [SYMBOL_W-1:0] ch);
    numeral_beat_t b;
    b.symbol      = ch;
    b.last        = 1'b0;
    b.range_error = 1'b0;
    numeral_q.push_back(b);
  endfunction

  // Appends the expected beats for one value, thousands first.
  function automatic void queue_numeral(input logic [VALUE_W-1:0] v);
    int unsigned         n;
    int unsigned         d;
    int unsigned         scale;
    int                  p;
    logic [SYMBOL_W-1:0] one;
    logic [SYMBOL_W-1:0] five;
    logic [SYMBOL_W-1:0] ten;
    numeral_beat_t       b;
    n = v;
    if (n == 0 || n > MAX_VALID) begin
      b.symbol      = CH_NONE;
      b.last        = 1'b1;
      b.range_error = 1'b1;
      numeral_q.push_back(b);
      return;
    end
    scale = 1000;
    for (p = 3; p >= 0; p--) begin
      d = (n / scale) % 10;
      scale = scale / 10;
      case (p)
        0: begin
          one = CH_I; five = CH_V; ten = CH_X;
        end
        1: begin
          one = CH_X; five = CH_L; ten = CH_C;
        end
        2: begin
          one = CH_C; five = CH_D; ten = CH_M;
        end
        default: begin
          one = CH_M; five = CH_NONE; ten = CH_NONE;
        end
      endcase
      if (d == 9) begin
        push_char(one);
        push_char(ten);
      end else if (d == 4) begin
        push_char(one);
        push_char(five);
      end else begin
        if (d >= 5) begin
          push_char(five);
          d = d - 5;
        end
        repeat (d) push_char(one);
      end
    end
    b = numeral_q.pop_back();
    b.last = 1'b1;
    numeral_q.push_back(b);
  endfunction

  always @(posedge clk) begin
    numeral_beat_t want;
    if (!rst) begin
      if (in_valid && !in_stall) queue_numeral(value);
      if (out_valid && !out_stall) begin
        if (numeral_q.size() == 0) begin
          $error("beat with nothing expected: symbol %h last %b range_error %b",
                 symbol, last, range_error);
          fail_count++;
        end else begin
          want = numeral_q.pop_front();
          if (symbol !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, symbol);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            fail_count++;
          end
          if (range_error !== want.range_error) begin
            $error("range_error: expected %b, got %b", want.range_error, range_error);
            fail_count++;
          end
        end
      end
      pending = numeral_q.size();
    end
  end

endmodule

/* test/tb_binary_to_roman_numeral.sv */
// Testbench top for binary_to_roman_numeral: clock, reset, value stimulus and
// output stall; checking is done by roman_check. Depends on btr_pkg.
`timescale 1ns / 1ps

module tb_binary_to_roman_numeral;
  import btr_pkg::*;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic [VALUE_W-1:0]  value       = '0;
  logic                out_stall   = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;
  logic                range_error;
  int                  fail_count;
  int                  pending;
  int                  gap_pct     = 0;
  int                  stall_pct   = 0;

  always #2 clk = ~clk;

  binary_to_roman_numeral u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last),
    .range_error (range_error)
  );

  roman_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last),
    .range_error (range_error),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // One beat on the input channel, with random gaps ahead of it.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      value    <= VALUE_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 5)
        send_value(VALUE_W'($urandom_range(4095, 4000)));
      else if (r < 8)
        send_value('0);
      else if (r < 20)
        send_value(VALUE_W'($urandom_range(20, 1)));
      else
        send_value(VALUE_W'($urandom_range(3999, 1)));
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    logic [VALUE_W-1:0] directed [$];
    directed = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd3999, 12'd4000, 12'd4095,
                 12'd3888, 12'd2047, 12'd1994, 12'd444, 12'd999, 12'd40, 12'd90,
                 12'd400, 12'd900, 12'd3000, 12'd1000, 12'h555, 12'h aaa, 12'd3,
                 12'd8, 12'd49, 12'd3549};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct   = 26;
    stall_pct = 69;
    foreach (directed[i]) send_value(directed[i]);
    // hold the input until the output side has caught up
    drain();
    send_random(150);
    drain();

    gap_pct   = 69;
    stall_pct = 26;
    send_random(150);
    drain();

    gap_pct   = 0;
    stall_pct = 0;
    send_random(155);
    drain();

    repeat (32) @(posedge clk);
    if (fail_count == 0)
      $display("binary_to_roman_numeral test passed");
    else
      $display("binary_to_roman_numeral test failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("binary_to_roman_numeral test failed");
    $finish;
  end

endmodule

/* sim.f */
sv/btr_pkg.sv
sv/btr_ctrl.sv
sv/btr_dp.sv
sv/binary_to_roman_numeral.sv
test/roman_check.sv
test/tb_binary_to_roman_numeral.sv
